[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; the including scope provides clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TAQE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included.
`define TAQE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/taqe_pkg.sv]
// Shared constants, types and helper functions of the ancestor query engine.
// Depends on nothing; every other RTL file but taqe_ram imports it.
package taqe_pkg;

   // Sizing of the stored tree
   localparam int MAX_NODES   = 1024;
   localparam int JUMP_LEVELS = 10;

   // Fixed field widths of the interface
   localparam int FIELD_W   = 10;
   localparam int DEPTH_W   = 10;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

   localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int LVL_W  = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
   localparam int RED_W  = FIELD_W + 18;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [LVL_W-1:0]  lvl_type;
   typedef logic [DEPTH_W-1:0] depth_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_INIT,
      ST_LD_JRD,
      ST_LD_JWR,
      ST_Q_RD,
      ST_Q_CMP,
      ST_LIFT,
      ST_LIFT_WR,
      ST_CHK,
      ST_UP_RD,
      ST_UP_CMP,
      ST_FIN_RD,
      ST_FIN,
      ST_EMIT
   } taqe_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic ld_init;
      logic ld_step;
      logic rd_prev;
      logic q_cmp;
      logic lift_skip;
      logic lift_take;
      logic up_init;
      logic up_step;
      logic fin;
      logic emit;
   } taqe_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic lvl_last;
      logic lvl_zero;
      logic diff_top;
      logic same;
      logic rsp_free;
   } taqe_stat_type;

   // Reduce a field value to a node index modulo MAX_NODES by shifted subtraction
   function automatic node_type node_reduce(input logic [FIELD_W-1:0] v);
      logic [RED_W-1:0] r;
      r = RED_W'(v);
      for (int k = FIELD_W - 1; k >= 0; k--) begin
         if (r >= (RED_W'(MAX_NODES) << k)) begin
            r = r - (RED_W'(MAX_NODES) << k);
         end
      end
      return NODE_W'(r);
   endfunction

endpackage

[rtl/taqe_ram.sv]
// Generic RAM: one write port and two registered read ports.
// Depends on nothing.
module taqe_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr_a,
   input  logic [AW-1:0]    raddr_b,
   output logic [WIDTH-1:0] rdata_a,
   output logic [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // Write one entry, read two
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

[rtl/taqe_ctrl.sv]
// Controller state machine of the ancestor query engine.
// Depends on taqe_pkg for the state enum and the command and status structs.
module taqe_ctrl import taqe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_op,
   output logic          req_ready,
   input  taqe_stat_type stat,
   output taqe_cmd_type  cmd
);

   taqe_state_type state_ff;
   taqe_state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through the load and query sequences
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_QUERY) ? ST_Q_RD : ST_LD_RD;
            end
         end
         ST_LD_RD:   state_in = ST_LD_INIT;
         ST_LD_INIT: state_in = (JUMP_LEVELS == 1) ? ST_IDLE : ST_LD_JRD;
         ST_LD_JRD:  state_in = ST_LD_JWR;
         ST_LD_JWR:  state_in = stat.lvl_last ? ST_IDLE : ST_LD_JRD;
         ST_Q_RD:    state_in = ST_Q_CMP;
         ST_Q_CMP:   state_in = ST_LIFT;
         ST_LIFT: begin
            if (stat.diff_top) begin
               state_in = ST_LIFT_WR;
            end else if (stat.lvl_zero) begin
               state_in = ST_CHK;
            end
         end
         ST_LIFT_WR: state_in = stat.lvl_zero ? ST_CHK : ST_LIFT;
         ST_CHK:     state_in = stat.same ? ST_EMIT : ST_UP_RD;
         ST_UP_RD:   state_in = ST_UP_CMP;
         ST_UP_CMP:  state_in = stat.lvl_zero ? ST_FIN_RD : ST_UP_RD;
         ST_FIN_RD:  state_in = ST_FIN;
         ST_FIN:     state_in = ST_EMIT;
         ST_EMIT:    state_in = stat.rsp_free ? ST_IDLE : ST_EMIT;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Drive datapath commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_LD_INIT: cmd.ld_init = 1'b1;
         ST_LD_JWR: begin
            cmd.ld_step = 1'b1;
            cmd.rd_prev = 1'b1;
         end
         ST_Q_CMP:   cmd.q_cmp     = 1'b1;
         ST_LIFT:    cmd.lift_skip = !stat.diff_top;
         ST_LIFT_WR: cmd.lift_take = 1'b1;
         ST_CHK:     cmd.up_init   = !stat.same;
         ST_UP_CMP:  cmd.up_step   = 1'b1;
         ST_FIN:     cmd.fin       = 1'b1;
         ST_EMIT:    cmd.emit      = stat.rsp_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[rtl/taqe_dp.sv]
// Datapath: node registers, level counter, depth and jump-table RAMs, result register.
// Depends on taqe_pkg and taqe_ram.
module taqe_dp import taqe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  taqe_cmd_type       cmd,
   output taqe_stat_type      stat,
   input  logic [FIELD_W-1:0] req_first_node,
   input  logic [FIELD_W-1:0] req_second_node,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FIELD_W-1:0] rsp_ancestor_node
);

   node_type                 a_ff, a_in;
   node_type                 b_ff, b_in;
   lvl_type                  lvl_ff, lvl_in;
   logic [JUMP_LEVELS-1:0]   diff_ff, diff_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]       rsp_node_ff, rsp_node_in;

   depth_type                depth_a, depth_b, depth_new, depth_gap;
   node_type                 jump_rd_a [JUMP_LEVELS];
   node_type                 jump_rd_b [JUMP_LEVELS];
   node_type                 jump_wdata;
   lvl_type                  sel_lvl;
   node_type                 up_a, up_b;
   logic [DEPTH_W+JUMP_LEVELS-1:0] gap_wide;
   logic [FIELD_W+NODE_W-1:0]      node_wide;

   localparam lvl_type LVL_LAST = LVL_W'(JUMP_LEVELS - 1);

   // Depth store, read at both current nodes
   taqe_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_depth_ram (
      .clock   (clock),
      .we      (cmd.ld_init),
      .waddr   (a_ff),
      .wdata   (depth_new),
      .raddr_a (a_ff),
      .raddr_b (b_ff),
      .rdata_a (depth_a),
      .rdata_b (depth_b)
   );

   // One jump RAM per level
   for (genvar g = 0; g < JUMP_LEVELS; g++) begin : g_level
      logic we_lvl;
      assign we_lvl = (cmd.ld_init && (g == 0)) ||
                      (cmd.ld_step && (lvl_ff == LVL_W'(g)));
      taqe_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_jump_ram (
         .clock   (clock),
         .we      (we_lvl),
         .waddr   (a_ff),
         .wdata   (jump_wdata),
         .raddr_a (a_ff),
         .raddr_b (b_ff),
         .rdata_a (jump_rd_a[g]),
         .rdata_b (jump_rd_b[g])
      );
   end

   // Select the jump level: one below the level counter on a load step, else the counter's own
   always_comb begin
      sel_lvl    = cmd.rd_prev ? (lvl_ff - LVL_W'(1)) : lvl_ff;
      up_a       = jump_rd_a[sel_lvl];
      up_b       = jump_rd_b[sel_lvl];
      jump_wdata = cmd.ld_init ? b_ff : up_b;
   end

   // Child depth saturates, a root sits at depth zero
   always_comb begin
      if (a_ff == b_ff) begin
         depth_new = '0;
      end else if (depth_b >= DEPTH_MAX) begin
         depth_new = DEPTH_MAX;
      end else begin
         depth_new = depth_b + DEPTH_W'(1);
      end
      depth_gap = (depth_a > depth_b) ? (depth_a - depth_b) : (depth_b - depth_a);
      gap_wide  = {{JUMP_LEVELS{1'b0}}, depth_gap};
      node_wide = {{FIELD_W{1'b0}}, a_ff};
   end

   // Next values of node registers, level counter and lift mask
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      lvl_in  = lvl_ff;
      diff_in = diff_ff;
      if (cmd.capture) begin
         a_in = node_reduce(req_first_node);
         b_in = node_reduce(req_second_node);
      end
      if (cmd.ld_init) begin
         lvl_in = LVL_W'(1);
      end
      if (cmd.ld_step) begin
         b_in   = up_b;
         lvl_in = lvl_ff + LVL_W'(1);
      end
      if (cmd.q_cmp) begin
         if (depth_a > depth_b) begin
            a_in = b_ff;
            b_in = a_ff;
         end
         diff_in = gap_wide[JUMP_LEVELS-1:0];
         lvl_in  = LVL_LAST;
      end
      if (cmd.lift_skip || cmd.lift_take) begin
         diff_in = diff_ff << 1;
         if (lvl_ff != '0) begin
            lvl_in = lvl_ff - LVL_W'(1);
         end
      end
      if (cmd.lift_take) begin
         b_in = up_b;
      end
      if (cmd.up_init) begin
         lvl_in = LVL_LAST;
      end
      if (cmd.up_step) begin
         if (up_a != up_b) begin
            a_in = up_a;
            b_in = up_b;
         end
         if (lvl_ff != '0) begin
            lvl_in = lvl_ff - LVL_W'(1);
         end
      end
      if (cmd.fin) begin
         a_in = up_a;
      end
   end

   // Load result register, drop it once taken
   always_comb begin
      rsp_node_in  = rsp_node_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_node_in  = node_wide[FIELD_W-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      lvl_ff      <= lvl_in;
      diff_ff     <= diff_in;
      rsp_node_ff <= rsp_node_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.lvl_last = (lvl_ff == LVL_LAST);
   assign stat.lvl_zero = (lvl_ff == '0);
   assign stat.diff_top = diff_ff[JUMP_LEVELS-1];
   assign stat.same     = (a_ff == b_ff);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ancestor_node = rsp_node_ff;

endmodule

[rtl/tree_ancestor_query_engine.sv]
// Top level of the binary-lifting lowest-common-ancestor engine.
// Depends on taqe_pkg, taqe_ctrl, taqe_dp (and through it taqe_ram).
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  req_op, req_first_node, req_second_node
//   rsp_     out        rsp_valid/rsp_ready  rsp_ancestor_node
//
// One transaction at a time. A load does one jump RAM read and write per level. A query
// lifts the deeper node by the depth gap, with one extra step per set bit of the gap;
// when the lift lands on the other node it is done, else it lifts both nodes level by
// level and takes their parent. The result sits in an output register; a new
// transaction is taken while it waits, and a later query stalls until it is taken.
// Reset is synchronous and clears control state only; RAM contents are kept.
module tree_ancestor_query_engine import taqe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [FIELD_W-1:0] req_first_node,
   input  logic [FIELD_W-1:0] req_second_node,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FIELD_W-1:0] rsp_ancestor_node
);

   taqe_cmd_type  cmd;
   taqe_stat_type stat;

   taqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   taqe_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_first_node    (req_first_node),
      .req_second_node   (req_second_node),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ancestor_node (rsp_ancestor_node)
   );

endmodule

[rtl/taqe_checker.sv]
// Port-level checker of the ancestor query engine, bound to the top level.
// Depends on taqe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module taqe_checker import taqe_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FIELD_W-1:0] rsp_ancestor_node
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   // Reset leaves the block idle with no pending result
   `TAQE_ASSERT_ALWAYS(a_reset_idle, reset |=> (req_ready && !rsp_valid), "not idle after reset")

   // An accepted transaction keeps the block busy in the next cycle
   `TAQE_ASSERT(a_busy_after_take, req_take |=> !req_ready, "ready right after a transaction")

   // No result appears in the cycle after a transaction is taken
   `TAQE_ASSERT(a_no_instant_rsp, (req_take && !rsp_valid) |=> !rsp_valid, "result too early")

   // A stalled result holds its value
   `TAQE_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ancestor_node)), "stalled result changed")

endmodule

bind tree_ancestor_query_engine taqe_checker u_taqe_checker (.*);

[verif/tb_tree_ancestor_query_engine.sv]
// Self-checking testbench for tree_ancestor_query_engine: drives load and query transactions,
// predicts every common ancestor in a scoreboard class and compares results in order.
// Depends on taqe_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;
   import taqe_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 60;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // Track tree state and the queue of ancestors still owed by the engine
   class lca_scoreboard_type;
      depth_type node_depth [MAX_NODES];
      node_type  jump_up [MAX_NODES][JUMP_LEVELS];
      node_type  pending_ancestors [$];
      int        errors;
      int        loads;
      int        queries;
      int        checked;

      function new();
         for (int n = 0; n < MAX_NODES; n++) begin
            node_depth[n] = '0;
            for (int l = 0; l < JUMP_LEVELS; l++) jump_up[n][l] = '0;
         end
         errors  = 0;
         loads   = 0;
         queries = 0;
         checked = 0;
      endfunction

      function node_type fold(logic [FIELD_W-1:0] v);
         return node_type'(int'(v) % MAX_NODES);
      endfunction

      // Attach a node below its parent and rebuild its jump table
      function void add_node(node_type n, node_type p);
         if (n == p) begin
            node_depth[n] = '0;
         end else begin
            node_depth[n] = (node_depth[p] >= DEPTH_MAX) ? DEPTH_MAX : node_depth[p] + 1'b1;
         end
         jump_up[n][0] = p;
         for (int l = 1; l < JUMP_LEVELS; l++) begin
            jump_up[n][l] = jump_up[jump_up[n][l-1]][l-1];
         end
      endfunction

      // Lift the deeper node, then both together, and return the meeting point
      function node_type lowest_common(node_type a, node_type b);
         node_type    t;
         node_type    ua;
         node_type    ub;
         int unsigned diff;
         if (node_depth[a] > node_depth[b]) begin
            t = a;
            a = b;
            b = t;
         end
         diff = node_depth[b] - node_depth[a];
         for (int l = JUMP_LEVELS - 1; l >= 0; l--) begin
            if (diff[l]) b = jump_up[b][l];
         end
         if (a == b) return a;
         for (int l = JUMP_LEVELS - 1; l >= 0; l--) begin
            ua = jump_up[a][l];
            ub = jump_up[b][l];
            if (ua != ub) begin
               a = ua;
               b = ub;
            end
         end
         return jump_up[a][0];
      endfunction

      function void note_request(logic op, logic [FIELD_W-1:0] f, logic [FIELD_W-1:0] s);
         node_type a;
         node_type b;
         a = fold(f);
         b = fold(s);
         if (op == OP_LOAD) begin
            add_node(a, b);
            loads++;
         end else begin
            pending_ancestors.insert(pending_ancestors.size(), lowest_common(a, b));
            queries++;
         end
      endfunction

      function void check_result(logic [FIELD_W-1:0] got);
         node_type want;
         if (pending_ancestors.size() == 0) begin
            $display("%0t ERROR: ancestor_node expected none, actual %0d", $time, got);
            errors++;
            return;
         end
         want = pending_ancestors.pop_front();
         checked++;
         if (got !== FIELD_W'(want)) begin
            $display("%0t ERROR: ancestor_node expected %0d, actual %0d", $time, want, got);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_ancestors.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_op;
   logic [FIELD_W-1:0] req_first_node;
   logic [FIELD_W-1:0] req_second_node;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [FIELD_W-1:0] rsp_ancestor_node;

   lca_scoreboard_type sb = new();

   int       send_idle_pct    = 0;
   int       rsp_stall_pct    = 0;
   bit       hold_off_request = 1'b0;
   bit       loaded [MAX_NODES];
   node_type loaded_list [$];
   node_type last_loaded;

   tree_ancestor_query_engine DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_first_node    (req_first_node),
      .req_second_node   (req_second_node),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ancestor_node (rsp_ancestor_node)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the engine hangs
   initial begin
      #16_000_000;
      $display("%0t ERROR: run did not complete in time", $time);
      $display("tree_ancestor_query_engine test failed");
      $finish;
   end

   // Drive the result side; honor a requested long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Sample both channels at the rising edge; results first, then new transactions
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_ancestor_node);
         if (req_valid && req_ready) sb.note_request(req_op, req_first_node, req_second_node);
      end
   end

   function void set_idling(idle_mode_type m);
      case (m)
         IDLE_NONE: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 73;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            rsp_stall_pct = 73;
         end
         default: begin
            send_idle_pct = 24;
            rsp_stall_pct = 24;
         end
      endcase
   endfunction

   function node_type pick_loaded();
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   // Offer one transaction and hold it until accepted
   task automatic send_item(logic op, node_type a, node_type b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_first_node  <= FIELD_W'(a);
      req_second_node <= FIELD_W'(b);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic load_item(node_type n, node_type p);
      if (!loaded[n]) begin
         loaded[n] = 1'b1;
         loaded_list.insert(loaded_list.size(), n);
      end
      last_loaded = n;
      send_item(OP_LOAD, n, p);
   endtask

   task automatic query_item(node_type a, node_type b);
      send_item(OP_QUERY, a, b);
   endtask

   // Drop valid and wait until every owed ancestor has come back
   task automatic settle_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   // Grow the forest with random loads and query random pairs of loaded nodes
   task automatic run_forest_phase(int items, idle_mode_type m);
      node_type n;
      node_type p;
      node_type a;
      int       r;
      set_idling(m);
      if (m == IDLE_RECEIVER) begin
         // Hold off the result side while queries keep coming, so the input stalls
         hold_off_request = 1'b1;
         repeat (6) query_item(pick_loaded(), pick_loaded());
      end
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(99);
         if (loaded_list.size() < 2 || r < 35) begin
            n = node_type'($urandom_range(MAX_NODES - 1));
            r = $urandom_range(99);
            if (r < 10) p = n;
            else if (r < 55) p = last_loaded;
            else p = pick_loaded();
            load_item(n, p);
         end else begin
            a = pick_loaded();
            if ($urandom_range(99) < 15) query_item(a, a);
            else query_item(a, pick_loaded());
         end
      end
   endtask

   // Thread every node into one chain, then close it on itself to saturate depth
   task automatic run_chain_phase();
      int order [MAX_NODES];
      int j;
      int t;
      for (int i = 0; i < MAX_NODES; i++) order[i] = i;
      for (int i = MAX_NODES - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      set_idling(IDLE_NONE);
      load_item(node_type'(order[0]), node_type'(order[0]));
      for (int i = 1; i < MAX_NODES; i++) begin
         if (i % 256 == 0) set_idling(idle_mode_type'((i / 256) % 4));
         load_item(node_type'(order[i]), node_type'(order[i-1]));
         if ($urandom_range(99) < 2) begin
            query_item(node_type'(order[$urandom_range(i)]), node_type'(order[$urandom_range(i)]));
         end
      end
      query_item(node_type'(order[MAX_NODES-1]), node_type'(order[0]));
      query_item(node_type'(order[1]), node_type'(order[MAX_NODES-1]));
      // Parent at maximum depth: the child's depth must clamp
      load_item(node_type'(order[0]), node_type'(order[MAX_NODES-1]));
      load_item(node_type'(order[1]), node_type'(order[0]));
      query_item(node_type'(order[0]), node_type'(order[2]));
      query_item(node_type'(order[MAX_NODES-1]), node_type'(order[1]));
      for (int i = 0; i < 20; i++) begin
         query_item(node_type'(order[$urandom_range(MAX_NODES - 1)]),
                    node_type'(order[$urandom_range(MAX_NODES - 1)]));
      end
   endtask

   // Main sequence
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_LOAD;
      req_first_node  = '0;
      req_second_node = '0;
      last_loaded     = '0;
      for (int n = 0; n < MAX_NODES; n++) loaded[n] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme indices, roots, ancestor pairs, split branches, separate trees
      set_idling(IDLE_NONE);
      load_item(10'd0, 10'd0);
      load_item(10'd1023, 10'd0);
      load_item(10'd512, 10'd1023);
      load_item(10'd1, 10'd0);
      load_item(10'd341, 10'd512);
      load_item(10'd682, 10'd341);
      load_item(10'd1022, 10'd1022);
      load_item(10'd1021, 10'd1022);
      query_item(10'd0, 10'd0);
      query_item(10'd1023, 10'd1023);
      query_item(10'd0, 10'd1023);
      query_item(10'd1023, 10'd0);
      query_item(10'd682, 10'd1);
      query_item(10'd1, 10'd682);
      query_item(10'd682, 10'd1023);
      query_item(10'd341, 10'd682);
      query_item(10'd512, 10'd1);
      query_item(10'd1021, 10'd682);
      query_item(10'd1022, 10'd1021);
      // Move a subtree under another branch, leaving its descendants' tables stale
      load_item(10'd1023, 10'd1);
      query_item(10'd682, 10'd1);
      settle_results();

      for (int m = 0; m < 4; m++) begin
         run_forest_phase(15, idle_mode_type'(m));
         settle_results();
      end
      run_chain_phase();
      settle_results();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d loads and %0d queries, %0d ancestors checked, %0d mismatches.",
               sb.loads, sb.queries, sb.checked, sb.errors);
      $display("Phases: edge cases, random forests, a full-depth chain with clamped depth, %s",
               "four idling mixes and a long result hold-off.");
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("tree_ancestor_query_engine test passed");
      end else begin
         $display("tree_ancestor_query_engine test failed");
      end
      $finish;
   end

endmodule
